/* rtl/brp_pkg.sv */
// shared types, codes and constants of the base relocation parser
`default_nettype none

package brp_pkg;

    // default block limit and result queue depth
    localparam int unsigned MAX_BLOCKS_DEFAULT  = 4096;
    localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

    // directory layout
    localparam int unsigned HDR_BYTES = 8;
    localparam logic [3:0]  TYPE_SKIP  = 4'd0;
    localparam logic [3:0]  TYPE_DIR64 = 4'd10;

    // configuration register indexes
    localparam logic [1:0] REG_DIR_OFFSET = 2'd0;
    localparam logic [1:0] REG_DIR_SIZE   = 2'd1;
    localparam logic [1:0] REG_IMAGE_SIZE = 2'd2;
    localparam logic [1:0] REG_DELTA      = 2'd3;

    typedef enum logic [1:0] {
        KIND_FIXUP = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ERR_NONE          = 4'd0,
        ERR_DIR_OUTSIDE   = 4'd1,
        ERR_TOO_MANY      = 4'd2,
        ERR_SMALL_BLOCK   = 4'd3,
        ERR_BLOCK_PAST    = 4'd4,
        ERR_ODD_ENTRIES   = 4'd5,
        ERR_TARGET_OUT    = 4'd6,
        ERR_BAD_TYPE      = 4'd7,
        ERR_RESIDUAL      = 4'd8
    } err_t;

    typedef enum logic [2:0] {
        PH_PAGE_LO = 3'd0,
        PH_PAGE_HI = 3'd1,
        PH_SIZE_LO = 3'd2,
        PH_SIZE_HI = 3'd3,
        PH_ENTRY   = 3'd4,
        PH_HALT    = 3'd5
    } phase_t;

    // one result word
    typedef struct packed {
        kind_t        kind;
        logic [32:0]  target;
        logic [30:0]  count;
        err_t         err;
        logic         last;
    } res_t;

    // queue entry: a result word plus an optional terminal word behind it
    typedef struct packed {
        res_t   head;
        logic   tail_valid;
        kind_t  tail_kind;
        err_t   tail_err;
    } entry_t;

endpackage

`default_nettype wire

/* rtl/brp_front.sv */
// front end: configuration registers, directory parse and classification
`default_nettype none

module brp_front #(
    parameter int unsigned MAX_BLOCKS = brp_pkg::MAX_BLOCKS_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_write,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [63:0]         cfg_data,
    input  wire logic                take,
    input  wire logic [15:0]         word,
    output logic                     push_valid,
    output brp_pkg::entry_t          push_entry,
    output logic [63:0]              delta
);

    localparam int unsigned BLK_W = $clog2(MAX_BLOCKS + 1);

    logic [31:0]       dir_offset_reg, dir_offset_next;
    logic [31:0]       dir_size_reg, dir_size_next;
    logic [31:0]       image_size_reg, image_size_next;
    logic [63:0]       delta_reg, delta_next;
    brp_pkg::phase_t   phase_reg, phase_next;
    logic [15:0]       page_lo_reg, page_lo_next;
    logic [31:0]       page_addr_reg, page_addr_next;
    logic [33:0]       page_plus8_reg, page_plus8_next;
    logic [15:0]       len_lo_reg, len_lo_next;
    logic [30:0]       entries_left_reg, entries_left_next;
    logic [31:0]       remaining_reg, remaining_next;
    logic [BLK_W-1:0]  blocks_seen_reg, blocks_seen_next;
    logic [30:0]       fixups_reg, fixups_next;

    logic              first_item;
    logic              dir_outside;
    logic [31:0]       block_len;
    logic [31:0]       rem_sel;
    logic [BLK_W-1:0]  blocks_inc;
    logic              bnd_has;
    brp_pkg::kind_t    bnd_kind;
    brp_pkg::err_t     bnd_err;
    logic [3:0]        etype;
    logic [32:0]       target;
    logic [33:0]       target_end;
    logic              last_entry;
    logic [30:0]       fixups_inc;

    assign delta = delta_reg;

    // shared datapath terms
    always_comb
    begin
        first_item  = (phase_reg == brp_pkg::PH_PAGE_LO) && (blocks_seen_reg == '0);
        dir_outside = ({1'b0, dir_offset_reg} + {1'b0, dir_size_reg}) > {1'b0, image_size_reg};
        block_len   = {word, len_lo_reg};
        rem_sel     = (phase_reg == brp_pkg::PH_ENTRY) ? remaining_reg
                                                       : remaining_reg - block_len;
        blocks_inc  = blocks_seen_reg + BLK_W'(1);
        etype       = word[15:12];
        target      = {1'b0, page_addr_reg} + {21'd0, word[11:0]};
        target_end  = page_plus8_reg + {22'd0, word[11:0]};
        last_entry  = (entries_left_reg == 31'd1);
        fixups_inc  = fixups_reg + 31'd1;
    end

    // loop condition at a block boundary
    always_comb
    begin
        bnd_has  = 1'b0;
        bnd_kind = brp_pkg::KIND_ERROR;
        bnd_err  = brp_pkg::ERR_NONE;
        if (rem_sel < 32'(brp_pkg::HDR_BYTES))
        begin
            bnd_has = 1'b1;
            if (rem_sel == 32'd0)
            begin
                bnd_kind = brp_pkg::KIND_DONE;
            end
            else
            begin
                bnd_err = brp_pkg::ERR_RESIDUAL;
            end
        end
        else if (blocks_inc >= BLK_W'(MAX_BLOCKS))
        begin
            bnd_has = 1'b1;
            bnd_err = brp_pkg::ERR_TOO_MANY;
        end
    end

    // next state and queue push
    always_comb
    begin
        dir_offset_next   = dir_offset_reg;
        dir_size_next     = dir_size_reg;
        image_size_next   = image_size_reg;
        delta_next        = delta_reg;
        phase_next        = phase_reg;
        page_lo_next      = page_lo_reg;
        page_addr_next    = page_addr_reg;
        page_plus8_next   = page_plus8_reg;
        len_lo_next       = len_lo_reg;
        entries_left_next = entries_left_reg;
        remaining_next    = remaining_reg;
        blocks_seen_next  = blocks_seen_reg;
        fixups_next       = fixups_reg;

        push_valid                 = 1'b0;
        push_entry.head.kind       = brp_pkg::KIND_ERROR;
        push_entry.head.target     = 33'd0;
        push_entry.head.count      = fixups_reg;
        push_entry.head.err        = brp_pkg::ERR_NONE;
        push_entry.head.last       = 1'b1;
        push_entry.tail_valid      = 1'b0;
        push_entry.tail_kind       = bnd_kind;
        push_entry.tail_err        = bnd_err;

        if (cfg_write)
        begin
            // any write restarts the parse
            case (cfg_index)
                brp_pkg::REG_DIR_OFFSET: dir_offset_next = cfg_data[31:0];
                brp_pkg::REG_DIR_SIZE:   dir_size_next   = cfg_data[31:0];
                brp_pkg::REG_IMAGE_SIZE: image_size_next = cfg_data[31:0];
                brp_pkg::REG_DELTA:      delta_next      = cfg_data;
                default:                 delta_next      = delta_reg;
            endcase
            phase_next        = brp_pkg::PH_PAGE_LO;
            entries_left_next = 31'd0;
            remaining_next    = dir_size_next;
            blocks_seen_next  = '0;
            fixups_next       = 31'd0;
        end
        else if (take && (dir_size_reg != 32'd0) && (phase_reg != brp_pkg::PH_HALT))
        begin
            if (first_item && dir_outside)
            begin
                push_valid          = 1'b1;
                push_entry.head.err = brp_pkg::ERR_DIR_OUTSIDE;
                phase_next          = brp_pkg::PH_HALT;
            end
            else if (first_item && (dir_size_reg < 32'(brp_pkg::HDR_BYTES)))
            begin
                push_valid          = 1'b1;
                push_entry.head.err = brp_pkg::ERR_RESIDUAL;
                phase_next          = brp_pkg::PH_HALT;
            end
            else
            begin
                case (phase_reg)
                    brp_pkg::PH_PAGE_LO:
                    begin
                        page_lo_next = word;
                        phase_next   = brp_pkg::PH_PAGE_HI;
                    end
                    brp_pkg::PH_PAGE_HI:
                    begin
                        page_addr_next  = {word, page_lo_reg};
                        page_plus8_next = {2'b00, word, page_lo_reg}
                                          + 34'(brp_pkg::HDR_BYTES);
                        phase_next      = brp_pkg::PH_SIZE_LO;
                    end
                    brp_pkg::PH_SIZE_LO:
                    begin
                        len_lo_next = word;
                        phase_next  = brp_pkg::PH_SIZE_HI;
                    end
                    brp_pkg::PH_SIZE_HI:
                    begin
                        // header checks in order: size, fit, parity
                        if (block_len < 32'(brp_pkg::HDR_BYTES))
                        begin
                            push_valid          = 1'b1;
                            push_entry.head.err = brp_pkg::ERR_SMALL_BLOCK;
                            phase_next          = brp_pkg::PH_HALT;
                        end
                        else if (block_len > remaining_reg)
                        begin
                            push_valid          = 1'b1;
                            push_entry.head.err = brp_pkg::ERR_BLOCK_PAST;
                            phase_next          = brp_pkg::PH_HALT;
                        end
                        else if (block_len[0])
                        begin
                            push_valid          = 1'b1;
                            push_entry.head.err = brp_pkg::ERR_ODD_ENTRIES;
                            phase_next          = brp_pkg::PH_HALT;
                        end
                        else
                        begin
                            remaining_next    = rem_sel;
                            entries_left_next = block_len[31:1] - 31'd4;
                            if (block_len == 32'(brp_pkg::HDR_BYTES))
                            begin
                                // header-only block ends at once
                                blocks_seen_next = blocks_inc;
                                phase_next       = brp_pkg::PH_PAGE_LO;
                                if (bnd_has)
                                begin
                                    push_valid           = 1'b1;
                                    push_entry.head.kind = bnd_kind;
                                    push_entry.head.err  = bnd_err;
                                    phase_next           = brp_pkg::PH_HALT;
                                end
                            end
                            else
                            begin
                                phase_next = brp_pkg::PH_ENTRY;
                            end
                        end
                    end
                    brp_pkg::PH_ENTRY:
                    begin
                        entries_left_next = entries_left_reg - 31'd1;
                        if ((etype != brp_pkg::TYPE_DIR64) && (etype != brp_pkg::TYPE_SKIP))
                        begin
                            push_valid          = 1'b1;
                            push_entry.head.err = brp_pkg::ERR_BAD_TYPE;
                            phase_next          = brp_pkg::PH_HALT;
                        end
                        else if ((etype == brp_pkg::TYPE_DIR64)
                                 && (target_end > {2'b00, image_size_reg}))
                        begin
                            push_valid          = 1'b1;
                            push_entry.head.err = brp_pkg::ERR_TARGET_OUT;
                            phase_next          = brp_pkg::PH_HALT;
                        end
                        else
                        begin
                            if (etype == brp_pkg::TYPE_DIR64)
                            begin
                                // fixup, possibly with the terminal word behind it
                                fixups_next            = fixups_inc;
                                push_valid             = 1'b1;
                                push_entry.head.kind   = brp_pkg::KIND_FIXUP;
                                push_entry.head.target = target;
                                push_entry.head.count  = fixups_inc;
                                push_entry.head.last   = 1'b0;
                                push_entry.tail_valid  = last_entry && bnd_has;
                            end
                            else if (last_entry && bnd_has)
                            begin
                                push_valid           = 1'b1;
                                push_entry.head.kind = bnd_kind;
                                push_entry.head.err  = bnd_err;
                            end
                            if (last_entry)
                            begin
                                blocks_seen_next = blocks_inc;
                                phase_next       = bnd_has ? brp_pkg::PH_HALT
                                                           : brp_pkg::PH_PAGE_LO;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_offset_reg   <= 32'd0;
            dir_size_reg     <= 32'd0;
            image_size_reg   <= 32'd0;
            delta_reg        <= 64'd0;
            phase_reg        <= brp_pkg::PH_PAGE_LO;
            entries_left_reg <= 31'd0;
            remaining_reg    <= 32'd0;
            blocks_seen_reg  <= '0;
            fixups_reg       <= 31'd0;
        end
        else
        begin
            dir_offset_reg   <= dir_offset_next;
            dir_size_reg     <= dir_size_next;
            image_size_reg   <= image_size_next;
            delta_reg        <= delta_next;
            phase_reg        <= phase_next;
            entries_left_reg <= entries_left_next;
            remaining_reg    <= remaining_next;
            blocks_seen_reg  <= blocks_seen_next;
            fixups_reg       <= fixups_next;
        end
    end

    // header payload registers
    always_ff @(posedge clk)
    begin
        page_lo_reg    <= page_lo_next;
        page_addr_reg  <= page_addr_next;
        page_plus8_reg <= page_plus8_next;
        len_lo_reg     <= len_lo_next;
    end

    // only a fixup may carry a terminal word behind it
    a_tail_after_fixup: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid && push_entry.tail_valid
        |-> push_entry.head.kind == brp_pkg::KIND_FIXUP && !push_entry.head.last)
        else $error("terminal word attached to a non-fixup");

    // halt is sticky until a configuration write
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == brp_pkg::PH_HALT && !cfg_write |=> phase_reg == brp_pkg::PH_HALT)
        else $error("parser left halt without a configuration write");

    // nothing is pushed once halted
    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == brp_pkg::PH_HALT |-> !push_valid)
        else $error("result pushed after halt");

endmodule

`default_nettype wire

/* rtl/brp_queue.sv */
// short result queue between parse front end and output back end
`default_nettype none

module brp_queue #(
    parameter int unsigned DEPTH = brp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    input  wire brp_pkg::entry_t  push_entry,
    input  wire logic             pop,
    output logic                  not_full,
    output logic                  pop_valid,
    output brp_pkg::entry_t       pop_entry
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    brp_pkg::entry_t   mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_pop;

    assign not_full  = (count_reg != CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_entry = mem_reg[rd_ptr_reg];
    assign do_pop    = pop && pop_valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_valid)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push_valid && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (!push_valid && do_pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // no push into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> count_reg != CNT_W'(DEPTH))
        else $error("push into full result queue");

endmodule

`default_nettype wire

/* rtl/brp_back.sv */
// back end: expands queue entries into result words on the output register
`default_nettype none

module brp_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_valid,
    input  wire brp_pkg::entry_t  q_entry,
    input  wire logic [63:0]      delta,
    output logic                  pop,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [1:0]            result_kind,
    output logic [32:0]           target_address,
    output logic signed [63:0]    adjustment,
    output logic [30:0]           applied_count,
    output logic [3:0]            error_code,
    output logic                  last
);

    logic              out_valid_reg, out_valid_next;
    brp_pkg::res_t     res_reg, res_next;
    logic [63:0]       adj_reg, adj_next;
    logic              tail_pend_reg, tail_pend_next;
    brp_pkg::kind_t    tail_kind_reg, tail_kind_next;
    brp_pkg::err_t     tail_err_reg, tail_err_next;
    logic              load;

    assign out_valid      = out_valid_reg;
    assign result_kind    = res_reg.kind;
    assign target_address = res_reg.target;
    assign adjustment     = adj_reg;
    assign applied_count  = res_reg.count;
    assign error_code     = res_reg.err;
    assign last           = res_reg.last;

    // output register load: pending terminal word first, then the queue
    always_comb
    begin
        load           = !out_valid_reg || out_ready;
        pop            = 1'b0;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        adj_next       = adj_reg;
        tail_pend_next = tail_pend_reg;
        tail_kind_next = tail_kind_reg;
        tail_err_next  = tail_err_reg;
        if (load)
        begin
            if (tail_pend_reg)
            begin
                out_valid_next  = 1'b1;
                res_next.kind   = tail_kind_reg;
                res_next.target = 33'd0;
                res_next.err    = tail_err_reg;
                res_next.last   = 1'b1;
                adj_next        = 64'd0;
                tail_pend_next  = 1'b0;
            end
            else if (q_valid)
            begin
                pop            = 1'b1;
                out_valid_next = 1'b1;
                res_next       = q_entry.head;
                adj_next       = (q_entry.head.kind == brp_pkg::KIND_FIXUP) ? delta : 64'd0;
                tail_pend_next = q_entry.tail_valid;
                tail_kind_next = q_entry.tail_kind;
                tail_err_next  = q_entry.tail_err;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            tail_pend_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            tail_pend_reg <= tail_pend_next;
        end
    end

    // output payload registers
    always_ff @(posedge clk)
    begin
        res_reg       <= res_next;
        adj_reg       <= adj_next;
        tail_kind_reg <= tail_kind_next;
        tail_err_reg  <= tail_err_next;
    end

    // a pending terminal word always sits behind a shown fixup
    a_tail_behind_fixup: assert property (@(posedge clk) disable iff (!rst_n)
        tail_pend_reg |-> out_valid_reg && !res_reg.last
                          && res_reg.kind == brp_pkg::KIND_FIXUP)
        else $error("terminal word pending without a fixup in front");

    // terminal word follows right after its fixup is taken
    a_tail_next: assert property (@(posedge clk) disable iff (!rst_n)
        tail_pend_reg && out_ready |=> out_valid_reg && res_reg.last)
        else $error("terminal word not shown after its fixup");

endmodule

`default_nettype wire

/* rtl/base_relocation_parser.sv */
// Base relocation directory parser: parses a relocation directory stream
// fed one 16-bit halfword per input word and emits fixup, done and error words.
// Input channel: in_valid/in_ready with payload word; one halfword is accepted
// per cycle while the result queue has room. Output channel: out_valid/out_ready
// with result_kind, target_address, adjustment, applied_count, error_code, last.
// Configuration: cfg_write with cfg_index and cfg_data, written at once, and
// each write restarts the parse; write only while no results are outstanding.
// Path: a result word enters the result queue when its halfword is accepted
// and moves to the output register once it is free and no terminal word waits.
// Throughput: one halfword per cycle while the queue has room; the output
// register drains one word per cycle while out_ready is high, and the halfword
// ending a directory with a fixup yields two words.
// Reset: control registers zero, so a zero-size directory drops every word.
// When the receiver stalls, the result queue (4 entries by default) fills and
// in_ready drops; it rises again as soon as the back end frees an entry.
`default_nettype none

module base_relocation_parser #(
    parameter int unsigned MAX_BLOCKS  = brp_pkg::MAX_BLOCKS_DEFAULT,
    parameter int unsigned QUEUE_DEPTH = brp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_write,
    input  wire logic [1:0]     cfg_index,
    input  wire logic [63:0]    cfg_data,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [15:0]    word,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [1:0]          result_kind,
    output logic [32:0]         target_address,
    output logic signed [63:0]  adjustment,
    output logic [30:0]         applied_count,
    output logic [3:0]          error_code,
    output logic                last
);

    logic             take;
    logic             push_valid;
    brp_pkg::entry_t  push_entry;
    logic             pop;
    logic             q_valid;
    brp_pkg::entry_t  q_entry;
    logic [63:0]      delta;

    // input handshake
    assign take = in_valid && in_ready;

    brp_front #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .take       (take),
        .word       (word),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .delta      (delta)
    );

    brp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .pop        (pop),
        .not_full   (in_ready),
        .pop_valid  (q_valid),
        .pop_entry  (q_entry)
    );

    brp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_entry        (q_entry),
        .delta          (delta),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_kind    (result_kind),
        .target_address (target_address),
        .adjustment     (adjustment),
        .applied_count  (applied_count),
        .error_code     (error_code),
        .last           (last)
    );

endmodule

`default_nettype wire
